// File: src/ts_pkg.sv
// Shared types, codes and character tables for the token scanner.
package ts_pkg;

  // Scanner modes.
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_IDENT  = 3'd1;
  localparam logic [2:0] MODE_NUMBER = 3'd2;
  localparam logic [2:0] MODE_STRING = 3'd3;
  localparam logic [2:0] MODE_HALT   = 3'd4;

  // Token kinds.
  localparam logic [2:0] KIND_IDENT   = 3'd0;
  localparam logic [2:0] KIND_KEYWORD = 3'd1;
  localparam logic [2:0] KIND_NUMBER  = 3'd2;
  localparam logic [2:0] KIND_STRING  = 3'd3;
  localparam logic [2:0] KIND_PUNCT   = 3'd4;
  localparam logic [2:0] KIND_EOF     = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;

  // Input actions.
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam logic [2:0] KW_NONE  = 3'd0;
  localparam int         KW_COUNT = 6;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

  // Result writes into the output queue for one processed item.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c inside {8'h20, [8'h09:8'h0D]});
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  // + - * / = ( ) ; { } [ ] < > , & | !
  function automatic logic is_punct(input logic [7:0] c);
    return (c inside {8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h28, 8'h29, 8'h3B, 8'h7B,
                      8'h7D, 8'h5B, 8'h5D, 8'h3C, 8'h3E, 8'h2C, 8'h26, 8'h7C, 8'h21});
  endfunction

  // Keyword lengths: int, return, if, else, while, for.
  function automatic logic [2:0] kw_len(input logic [2:0] k);
    logic [2:0] r;
    case (k)
      3'd0:    r = 3'd3;
      3'd1:    r = 3'd6;
      3'd2:    r = 3'd2;
      3'd3:    r = 3'd4;
      3'd4:    r = 3'd5;
      3'd5:    r = 3'd3;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Character at position idx of keyword k; zero past its end.
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] idx);
    logic [7:0] r;
    case ({k, idx})
      {3'd0, 3'd0}: r = "i";
      {3'd0, 3'd1}: r = "n";
      {3'd0, 3'd2}: r = "t";
      {3'd1, 3'd0}: r = "r";
      {3'd1, 3'd1}: r = "e";
      {3'd1, 3'd2}: r = "t";
      {3'd1, 3'd3}: r = "u";
      {3'd1, 3'd4}: r = "r";
      {3'd1, 3'd5}: r = "n";
      {3'd2, 3'd0}: r = "i";
      {3'd2, 3'd1}: r = "f";
      {3'd3, 3'd0}: r = "e";
      {3'd3, 3'd1}: r = "l";
      {3'd3, 3'd2}: r = "s";
      {3'd3, 3'd3}: r = "e";
      {3'd4, 3'd0}: r = "w";
      {3'd4, 3'd1}: r = "h";
      {3'd4, 3'd2}: r = "i";
      {3'd4, 3'd3}: r = "l";
      {3'd4, 3'd4}: r = "e";
      {3'd5, 3'd0}: r = "f";
      {3'd5, 3'd1}: r = "o";
      {3'd5, 3'd2}: r = "r";
      default:      r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// File: src/ts_core.sv
// Scanner state and the single-pass step logic that turns one item into up to two results.
module ts_core #(
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16,
  parameter int LENGTH_BITS = 12,
  localparam int DB = LINE_BITS + COLUMN_BITS + LENGTH_BITS + 11,
  localparam int EW = DB + 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic             action,
  input  logic [7:0]       char_code,
  output ts_pkg::push_t    push,
  output logic [EW-1:0]    entry0,
  output logic [EW-1:0]    entry1
);

  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
  localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

  logic [2:0]             mode, mode_next;
  logic [LINE_BITS-1:0]   line, line_next;
  logic [COLUMN_BITS-1:0] col, col_next;
  logic [COLUMN_BITS-1:0] scol, scol_next;
  logic [LENGTH_BITS-1:0] len, len_next;
  logic [5:0]             kwmask, kwmask_next;

  // Entry layout from the low bit: line, column, length, keyword, char, kind, last.
  function automatic logic [EW-1:0] mk(input logic [2:0] kind,
                                       input logic [LINE_BITS-1:0] l,
                                       input logic [COLUMN_BITS-1:0] cl,
                                       input logic [LENGTH_BITS-1:0] n,
                                       input logic [2:0] kw,
                                       input logic [7:0] ch);
    return {1'b0, kind, ch, kw, n, cl, l};
  endfunction

  logic [2:0]             pend_kw;
  logic                   pend_v, sec_v, idle_path;
  logic [EW-1:0]          pend_r, sec_r;
  logic [LENGTH_BITS-1:0] len_inc;
  logic [LINE_BITS-1:0]   line_step;
  logic [COLUMN_BITS-1:0] col_step;
  logic [5:0]             mask_hit, mask_first;

  always_comb begin
    len_inc   = (len == LEN_MAX) ? len : len + LENGTH_BITS'(1);
    line_step = line;
    col_step  = (col == COL_MAX) ? col : col + COLUMN_BITS'(1);
    if (char_code == ts_pkg::CH_NEWLINE) begin
      line_step = (line == LINE_MAX) ? line : line + LINE_BITS'(1);
      col_step  = COL_ONE;
    end

    // Keyword candidates that survive this character, continuing or starting a word.
    for (int k = 0; k < ts_pkg::KW_COUNT; k++) begin
      mask_hit[k] = (len < LENGTH_BITS'(ts_pkg::kw_len(3'(k)))) &&
                    (ts_pkg::kw_char(3'(k), len[2:0]) == char_code);
      mask_first[k] = (ts_pkg::kw_char(3'(k), 3'd0) == char_code);
    end

    pend_kw = ts_pkg::KW_NONE;
    for (int k = 0; k < ts_pkg::KW_COUNT; k++) begin
      if (kwmask[k] && len == LENGTH_BITS'(ts_pkg::kw_len(3'(k)))) begin
        pend_kw = 3'(k + 1);
      end
    end

    case (mode)
      ts_pkg::MODE_IDENT:  pend_r = mk((pend_kw != ts_pkg::KW_NONE) ? ts_pkg::KIND_KEYWORD
                                       : ts_pkg::KIND_IDENT, line, scol, len, pend_kw, 8'h00);
      ts_pkg::MODE_NUMBER: pend_r = mk(ts_pkg::KIND_NUMBER, line, scol, len,
                                       ts_pkg::KW_NONE, 8'h00);
      default:             pend_r = mk(ts_pkg::KIND_STRING, line, scol, len,
                                       ts_pkg::KW_NONE, 8'h00);
    endcase

    mode_next   = mode;
    line_next   = line;
    col_next    = col;
    scol_next   = scol;
    len_next    = len;
    kwmask_next = kwmask;
    pend_v      = 1'b0;
    sec_v       = 1'b0;
    sec_r       = mk(ts_pkg::KIND_EOF, line, col, '0, ts_pkg::KW_NONE, 8'h00);
    idle_path   = 1'b0;

    if (action == ts_pkg::ACT_END) begin
      if (mode != ts_pkg::MODE_HALT) begin
        pend_v = (mode == ts_pkg::MODE_IDENT) || (mode == ts_pkg::MODE_NUMBER) ||
                 (mode == ts_pkg::MODE_STRING);
        sec_v  = 1'b1;
      end
      mode_next   = ts_pkg::MODE_IDLE;
      line_next   = LINE_ONE;
      col_next    = COL_ONE;
      scol_next   = COL_ONE;
      len_next    = '0;
      kwmask_next = '1;
    end else begin
      case (mode)
        ts_pkg::MODE_HALT: begin
        end
        ts_pkg::MODE_IDENT: begin
          if (ts_pkg::is_word(char_code)) begin
            kwmask_next = kwmask & mask_hit;
            len_next    = len_inc;
            line_next   = line_step;
            col_next    = col_step;
          end else begin
            pend_v    = 1'b1;
            idle_path = 1'b1;
          end
        end
        ts_pkg::MODE_NUMBER: begin
          if (ts_pkg::is_digit(char_code)) begin
            len_next  = len_inc;
            line_next = line_step;
            col_next  = col_step;
          end else begin
            pend_v    = 1'b1;
            idle_path = 1'b1;
          end
        end
        ts_pkg::MODE_STRING: begin
          if (char_code == ts_pkg::CH_QUOTE) begin
            pend_v    = 1'b1;
            mode_next = ts_pkg::MODE_IDLE;
          end else begin
            len_next = len_inc;
          end
          line_next = line_step;
          col_next  = col_step;
        end
        default: idle_path = 1'b1;
      endcase

      // Between tokens; a pending word or number leaves line and column untouched.
      if (idle_path) begin
        mode_next = ts_pkg::MODE_IDLE;
        if (ts_pkg::is_space(char_code)) begin
          line_next = line_step;
          col_next  = col_step;
        end else if (ts_pkg::is_alpha(char_code) || char_code == ts_pkg::CH_UNDER) begin
          mode_next   = ts_pkg::MODE_IDENT;
          scol_next   = col;
          len_next    = LENGTH_BITS'(1);
          kwmask_next = mask_first;
          line_next   = line_step;
          col_next    = col_step;
        end else if (ts_pkg::is_digit(char_code)) begin
          mode_next = ts_pkg::MODE_NUMBER;
          scol_next = col;
          len_next  = LENGTH_BITS'(1);
          line_next = line_step;
          col_next  = col_step;
        end else if (char_code == ts_pkg::CH_QUOTE) begin
          mode_next = ts_pkg::MODE_STRING;
          scol_next = col_step;
          len_next  = '0;
          line_next = line_step;
          col_next  = col_step;
        end else if (ts_pkg::is_punct(char_code)) begin
          sec_v     = 1'b1;
          sec_r     = mk(ts_pkg::KIND_PUNCT, line, col, LENGTH_BITS'(1),
                         ts_pkg::KW_NONE, char_code);
          line_next = line_step;
          col_next  = col_step;
        end else begin
          sec_v     = 1'b1;
          sec_r     = mk(ts_pkg::KIND_ERROR, line, col, '0, ts_pkg::KW_NONE, char_code);
          mode_next = ts_pkg::MODE_HALT;
        end
      end
    end

    // The first slot takes the pending token when there is one; last marks the final slot.
    entry0       = pend_v ? pend_r : sec_r;
    entry0[EW-1] = !(pend_v && sec_v);
    entry1       = sec_r;
    entry1[EW-1] = 1'b1;
    push.first   = fire && (pend_v || sec_v);
    push.second  = fire && pend_v && sec_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= ts_pkg::MODE_IDLE;
      line   <= LINE_ONE;
      col    <= COL_ONE;
      scol   <= COL_ONE;
      len    <= '0;
      kwmask <= '1;
    end else if (fire) begin
      mode   <= mode_next;
      line   <= line_next;
      col    <= col_next;
      scol   <= scol_next;
      len    <= len_next;
      kwmask <= kwmask_next;
    end
  end

endmodule

// File: src/ts_fifo.sv
// Four-entry result queue that takes up to two results a cycle and gives one.
module ts_fifo #(
  parameter int EW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  ts_pkg::push_t push,
  input  logic [EW-1:0] entry0,
  input  logic [EW-1:0] entry1,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [EW-1:0] out_entry
);

  logic [EW-1:0] mem [4];
  logic [1:0]    wp, rp;
  logic [2:0]    count, count_next;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign out_entry = mem[rp];
  // Two free places are kept so that any item can be taken.
  assign room      = (count <= 3'd2);

  always_comb begin
    count_next = count + 3'(push.first) + 3'(push.second) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wp] <= entry0;
    end
    if (push.second) begin
      mem[wp + 2'd1] <= entry1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + 2'(push.first) + 2'(push.second);
      rp    <= rp + 2'(pop);
      count <= count_next;
    end
  end

endmodule

// File: src/token_scanner.sv
// Top level of the token scanner: input register, scanner core and result queue.
// Path: an accepted byte is held in the input register, and when the result queue has room the
// core step writes its results into the queue, from which they are offered on the m_ port.
// Throughput: one byte per cycle while the result queue has room; items that give two results
// are held back in steady streaming by the single result port draining the four-entry queue.
// Reset (rst, synchronous): scanner returns to line 1, column 1, between tokens,
// and the input register and result queue are emptied.
module token_scanner #(
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16,
  parameter int LENGTH_BITS = 12,
  localparam int DB  = LINE_BITS + COLUMN_BITS + LENGTH_BITS + 11,
  localparam int ODW = ((DB + 7) / 8) * 8,
  localparam int EW  = DB + 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     s_tdata,   // char_code
  input  logic           s_tuser,   // action
  output logic           m_tvalid,
  input  logic           m_tready,
  // line, column, length, keyword_number, token_char, zero fill
  output logic [ODW-1:0] m_tdata,
  output logic [2:0]     m_tuser,   // token_kind
  output logic           m_tlast
);

  logic          in_valid;
  logic          in_action;
  logic [7:0]    in_char;
  logic          room, fire;
  ts_pkg::push_t push;
  logic [EW-1:0] entry0, entry1, out_entry;

  assign fire     = in_valid && room;
  assign s_tready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_action <= s_tuser;
      in_char   <= s_tdata;
    end
  end

  ts_core #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .action    (in_action),
    .char_code (in_char),
    .push      (push),
    .entry0    (entry0),
    .entry1    (entry1)
  );

  ts_fifo #(
    .EW (EW)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry0    (entry0),
    .entry1    (entry1),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_entry (out_entry)
  );

  assign m_tdata = ODW'(out_entry[DB-1:0]);
  assign m_tuser = out_entry[DB+2:DB];
  assign m_tlast = out_entry[EW-1];

endmodule
